// ===== hw/rtl/jsu_pkg.sv =====
// Shared types and codes of the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

	localparam int unsigned MAX_ITEMS = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
	localparam logic [2:0] ERR_BAD_ESC = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX = 3'd3;
	localparam logic [2:0] ERR_UNTERM = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic [2:0] err;
	} item_t;

	typedef struct packed {
		logic [2:0] count;
		item_t [MAX_ITEMS-1:0] items;
	} bundle_t;

endpackage

// ===== hw/rtl/jsu_front.sv =====
// Front part: accepts source bytes, tracks the escape state and builds the result words.
`timescale 1ns / 1ps

module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	output jsu_pkg::bundle_t  bundle
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_STR,
		M_ESC,
		M_HEX,
		M_PBS,
		M_PU,
		M_LHEX
	} mode_t;

	typedef struct packed {
		logic [2:0] len;
		logic [3:0][7:0] b;
	} enc_t;

	typedef struct packed {
		logic has;
		jsu_pkg::item_t it;
		mode_t m;
	} step_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;

	mode_t mode_q, mode_d;
	logic [15:0] code_q, code_d;
	logic [15:0] held_q, held_d;
	logic [15:0] low_q, low_d;
	logic [1:0] dc_q, dc_d;

	function automatic jsu_pkg::item_t mk(input logic [7:0] d, input logic [1:0] k,
			input logic [2:0] e);
		jsu_pkg::item_t it;
		it.data = d;
		it.kind = k;
		it.err = e;
		return it;
	endfunction

	function automatic logic [4:0] hexval(input logic [7:0] b);
		logic [4:0] v;
		if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
		else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
		else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
		else v = 5'd16;
		return v;
	endfunction

	function automatic enc_t encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.len = 3'd1;
			e.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			e.len = 3'd2;
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			e.len = 3'd3;
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
		end else begin
			e.len = 3'd4;
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

	function automatic step_t str_byte(input logic [7:0] b);
		step_t s;
		s.has = 1'b1;
		s.m = M_STR;
		s.it = mk(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		if (b == 8'h00) begin
			s.it = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM);
			s.m = M_IDLE;
		end else if (b == CH_QUOTE) begin
			s.it = mk(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
			s.m = M_IDLE;
		end else if (b == CH_BSLASH) begin
			s.has = 1'b0;
			s.m = M_ESC;
		end
		return s;
	endfunction

	function automatic step_t esc_byte(input logic [7:0] b);
		step_t s;
		s.has = 1'b1;
		s.m = M_STR;
		s.it = mk(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		unique case (b)
			8'h00: begin
				s.it = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM);
				s.m = M_IDLE;
			end
			8'h22, 8'h5C, 8'h2F: ;
			8'h62: s.it.data = 8'h08;
			8'h66: s.it.data = 8'h0C;
			8'h6E: s.it.data = 8'h0A;
			8'h72: s.it.data = 8'h0D;
			8'h74: s.it.data = 8'h09;
			8'h75: begin
				s.has = 1'b0;
				s.m = M_HEX;
			end
			default: begin
				s.it = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_ESC);
				s.m = M_IDLE;
			end
		endcase
		return s;
	endfunction

	logic [4:0] h;
	logic [15:0] code_sh, low_sh;
	logic pre;
	logic use_cp;
	logic [20:0] cp;
	step_t st;
	enc_t main_enc, held_enc;
	jsu_pkg::item_t [3:0] main_items;
	logic [2:0] main_n;

	assign h = hexval(in_byte);
	assign code_sh = {code_q[11:0], h[3:0]};
	assign low_sh = {low_q[11:0], h[3:0]};
	assign held_enc = encode({5'd0, held_q});
	assign main_enc = encode(cp);

	always_comb begin
		mode_d = mode_q;
		code_d = code_q;
		held_d = held_q;
		low_d = low_q;
		dc_d = dc_q;
		pre = 1'b0;
		use_cp = 1'b0;
		cp = '0;
		st = '{has: 1'b0, it: '0, m: M_IDLE};
		unique case (mode_q)
			M_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					mode_d = M_STR;
				end else begin
					st.has = 1'b1;
					st.it = mk(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NO_QUOTE);
				end
			end
			M_STR: begin
				st = str_byte(in_byte);
				mode_d = st.m;
			end
			M_ESC: begin
				st = esc_byte(in_byte);
				mode_d = st.m;
				code_d = '0;
				dc_d = '0;
			end
			M_HEX: begin
				if (h[4]) begin
					st.has = 1'b1;
					st.it = mk(8'h00, jsu_pkg::KIND_ERROR,
						(in_byte == 8'h00) ? jsu_pkg::ERR_UNTERM : jsu_pkg::ERR_BAD_HEX);
					mode_d = M_IDLE;
				end else begin
					code_d = code_sh;
					dc_d = dc_q + 2'd1;
					if (dc_q == 2'd3) begin
						if (code_sh >= 16'hD800 && code_sh < 16'hDC00) begin
							held_d = code_sh;
							mode_d = M_PBS;
						end else begin
							use_cp = 1'b1;
							cp = {5'd0, code_sh};
							mode_d = M_STR;
						end
					end
				end
			end
			M_PBS: begin
				if (in_byte == CH_BSLASH) begin
					mode_d = M_PU;
				end else begin
					pre = 1'b1;
					st = str_byte(in_byte);
					mode_d = st.m;
				end
			end
			M_PU: begin
				if (in_byte == CH_U) begin
					low_d = '0;
					dc_d = '0;
					mode_d = M_LHEX;
				end else begin
					pre = 1'b1;
					st = esc_byte(in_byte);
					mode_d = st.m;
				end
			end
			M_LHEX: begin
				if (h[4]) begin
					pre = 1'b1;
					st.has = 1'b1;
					st.it = mk(8'h00, jsu_pkg::KIND_ERROR,
						(in_byte == 8'h00) ? jsu_pkg::ERR_UNTERM : jsu_pkg::ERR_BAD_HEX);
					mode_d = M_IDLE;
				end else begin
					low_d = low_sh;
					dc_d = dc_q + 2'd1;
					if (dc_q == 2'd3) begin
						if (low_sh >= 16'hDC00 && low_sh < 16'hE000) begin
							use_cp = 1'b1;
							cp = {1'b0, held_q[9:0], low_sh[9:0]} + 21'h10000;
							mode_d = M_STR;
						end else begin
							pre = 1'b1;
							if (low_sh >= 16'hD800 && low_sh < 16'hDC00) begin
								held_d = low_sh;
								mode_d = M_PBS;
							end else begin
								use_cp = 1'b1;
								cp = {5'd0, low_sh};
								mode_d = M_STR;
							end
						end
					end
				end
			end
			default: mode_d = M_IDLE;
		endcase
	end

	always_comb begin
		main_items = '0;
		main_n = '0;
		if (use_cp) begin
			main_n = main_enc.len;
			for (int i = 0; i < 4; i++) begin
				main_items[i] = mk(main_enc.b[i], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			end
		end else if (st.has) begin
			main_n = 3'd1;
			main_items[0] = st.it;
		end
	end

	always_comb begin
		bundle = '0;
		if (pre) begin
			for (int i = 0; i < 3; i++) begin
				bundle.items[i] = mk(held_enc.b[i], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			end
			for (int i = 0; i < 3; i++) begin
				bundle.items[i+3] = main_items[i];
			end
			bundle.count = 3'd3 + main_n;
		end else begin
			for (int i = 0; i < 4; i++) begin
				bundle.items[i] = main_items[i];
			end
			bundle.count = main_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			code_q <= '0;
			held_q <= '0;
			low_q <= '0;
			dc_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			code_q <= code_d;
			held_q <= held_d;
			low_q <= low_d;
			dc_q <= dc_d;
		end
	end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// Short queue of result bundles between the front and back parts.
`timescale 1ns / 1ps

module jsu_queue #(
	parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsu_pkg::bundle_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output jsu_pkg::bundle_t  head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	jsu_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/jsu_back.sv =====
// Back part: walks each bundle and sends its result words through the output register.
`timescale 1ns / 1ps

module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  jsu_pkg::bundle_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic [1:0]        item_kind,
	output logic [2:0]        error_code,
	output logic              last
);

	logic [2:0] idx_q;
	logic load;
	logic is_last;
	jsu_pkg::item_t cur;

	assign load = head_valid && (!out_valid || out_ready);
	assign cur = head.items[idx_q];
	assign is_last = (idx_q == head.count - 3'd1);
	assign pop = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte <= cur.data;
			item_kind <= cur.kind;
			error_code <= cur.err;
			last <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q <= is_last ? '0 : idx_q + 3'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/json_string_unescape_utf8_top.sv =====
// Top level of the JSON string unescaper to UTF-8.
// The result words of an input byte pass through the bundle queue and then the output register.
// One input byte per cycle while the bundle queue has room; the output register sends one result word
// per cycle while out_ready is high, and the bundle queue holds the words of bytes that give several.
// A new byte is taken whenever the bundle queue has room.
// Reset: arst_n clears the escape state to waiting for an opening quote and empties
// the queue and the output register.
`timescale 1ns / 1ps

module json_string_unescape_utf8_top #(
	parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] item_kind,
	output logic [2:0] error_code,
	output logic       last
);

	logic accept;
	logic full;
	logic pop;
	logic head_valid;
	jsu_pkg::bundle_t bundle;
	jsu_pkg::bundle_t head;

	assign in_ready = !full;
	assign accept = in_valid && in_ready;

	jsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.bundle  (bundle)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept && (bundle.count != 3'd0)),
		.push_data  (bundle),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.item_kind  (item_kind),
		.error_code (error_code),
		.last       (last)
	);

endmodule

// ===== test/tb_json_string_unescape_utf8_top.sv =====
// Self-checking testbench of the JSON string unescaper: directed bytes and random quoted strings checked word by word.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_top;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_BYTES = 250;
	localparam int unsigned HOLD_OFF_CYCLES = 64;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_TEXT,
		MODE_ESCAPE,
		MODE_HEX,
		MODE_AFTER_HIGH,
		MODE_HIGH_ESCAPE,
		MODE_LOW_HEX
	} unesc_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic [2:0] err;
		logic last;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] in_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] item_kind;
	logic [2:0] error_code;
	logic last;

	logic [7:0] pending_bytes[$];
	result_word_t expected_words[$];
	result_word_t step_words[$];

	unesc_mode_t unesc_mode;
	logic [15:0] code_acc;
	logic [15:0] held_high;
	logic [15:0] low_acc;
	logic [1:0] digit_cnt;

	int unsigned total_items = 0;
	int unsigned accepted_count = 0;
	int unsigned words_seen = 0;
	int unsigned closes_seen = 0;
	int unsigned errors_seen = 0;
	int unsigned input_stalls = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;

	json_string_unescape_utf8_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.item_kind(item_kind),
		.error_code(error_code),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [4:0] hex_value(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return 5'(b - "0");
		if (b >= "a" && b <= "f")
			return 5'(b - "a" + 10);
		if (b >= "A" && b <= "F")
			return 5'(b - "A" + 10);
		return 5'd16;
	endfunction

	function automatic bit escape_known(input logic [7:0] b);
		case (b)
			CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t", CH_U: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Decoder model: one input byte in, up to MAX_ITEMS result words out.
	task automatic add_word(input logic [7:0] d, input logic [1:0] k, input logic [2:0] e);
		if (step_words.size() < jsu_pkg::MAX_ITEMS)
			step_words.push_back('{data: d, kind: k, err: e, last: 1'b0});
	endtask

	task automatic fail_with(input logic [2:0] e);
		add_word(8'h00, jsu_pkg::KIND_ERROR, e);
		unesc_mode = MODE_IDLE;
	endtask

	task automatic put_code_point(input int unsigned cp);
		if (cp < 'h80) begin
			add_word(8'(cp), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end else if (cp < 'h800) begin
			add_word(8'('hC0 | (cp >> 6)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			add_word(8'('h80 | (cp & 'h3F)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end else if (cp < 'h10000) begin
			add_word(8'('hE0 | (cp >> 12)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			add_word(8'('h80 | ((cp >> 6) & 'h3F)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			add_word(8'('h80 | (cp & 'h3F)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end else begin
			add_word(8'('hF0 | ((cp >> 18) & 'h07)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			add_word(8'('h80 | ((cp >> 12) & 'h3F)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			add_word(8'('h80 | ((cp >> 6) & 'h3F)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			add_word(8'('h80 | (cp & 'h3F)), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end
	endtask

	task automatic take_code(input logic [15:0] cp);
		if (cp >= 16'hD800 && cp < 16'hDC00) begin
			held_high = cp;
			unesc_mode = MODE_AFTER_HIGH;
		end else begin
			put_code_point(cp);
			unesc_mode = MODE_TEXT;
		end
	endtask

	task automatic text_byte(input logic [7:0] b);
		if (b == CH_NUL) begin
			fail_with(jsu_pkg::ERR_UNTERM);
		end else if (b == CH_QUOTE) begin
			add_word(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
			unesc_mode = MODE_IDLE;
		end else if (b == CH_BSLASH) begin
			unesc_mode = MODE_ESCAPE;
		end else begin
			add_word(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
		end
	endtask

	task automatic escape_byte(input logic [7:0] b);
		logic [7:0] v;
		v = b;
		case (b)
			"b": v = 8'h08;
			"f": v = 8'h0C;
			"n": v = 8'h0A;
			"r": v = 8'h0D;
			"t": v = 8'h09;
			default: v = b;
		endcase
		if (b == CH_NUL) begin
			fail_with(jsu_pkg::ERR_UNTERM);
		end else if (b == CH_U) begin
			code_acc = 16'h0000;
			digit_cnt = 2'd0;
			unesc_mode = MODE_HEX;
		end else if (!escape_known(b)) begin
			fail_with(jsu_pkg::ERR_BAD_ESC);
		end else begin
			add_word(v, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
			unesc_mode = MODE_TEXT;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [4:0] h;
		result_word_t tail;
		h = hex_value(b);
		step_words.delete();
		case (unesc_mode)
			MODE_IDLE: begin
				if (b == CH_QUOTE)
					unesc_mode = MODE_TEXT;
				else
					fail_with(jsu_pkg::ERR_NO_QUOTE);
			end
			MODE_TEXT: text_byte(b);
			MODE_ESCAPE: escape_byte(b);
			MODE_HEX: begin
				if (h > 5'd15) begin
					fail_with(b == CH_NUL ? jsu_pkg::ERR_UNTERM : jsu_pkg::ERR_BAD_HEX);
				end else begin
					code_acc = {code_acc[11:0], h[3:0]};
					if (digit_cnt == 2'd3) begin
						digit_cnt = 2'd0;
						take_code(code_acc);
					end else begin
						digit_cnt = digit_cnt + 2'd1;
					end
				end
			end
			MODE_AFTER_HIGH: begin
				if (b == CH_BSLASH) begin
					unesc_mode = MODE_HIGH_ESCAPE;
				end else begin
					put_code_point(held_high);
					unesc_mode = MODE_TEXT;
					text_byte(b);
				end
			end
			MODE_HIGH_ESCAPE: begin
				if (b == CH_U) begin
					low_acc = 16'h0000;
					digit_cnt = 2'd0;
					unesc_mode = MODE_LOW_HEX;
				end else begin
					put_code_point(held_high);
					escape_byte(b);
				end
			end
			MODE_LOW_HEX: begin
				if (h > 5'd15) begin
					put_code_point(held_high);
					fail_with(b == CH_NUL ? jsu_pkg::ERR_UNTERM : jsu_pkg::ERR_BAD_HEX);
				end else begin
					low_acc = {low_acc[11:0], h[3:0]};
					if (digit_cnt != 2'd3) begin
						digit_cnt = digit_cnt + 2'd1;
					end else begin
						digit_cnt = 2'd0;
						if (low_acc >= 16'hDC00 && low_acc < 16'hE000) begin
							put_code_point('h10000 + ((int'(held_high) - 'hD800) << 10)
								+ (int'(low_acc) - 'hDC00));
							unesc_mode = MODE_TEXT;
						end else begin
							put_code_point(held_high);
							take_code(low_acc);
						end
					end
				end
			end
			default: unesc_mode = MODE_IDLE;
		endcase
		if (step_words.size() > 0) begin
			tail = step_words.pop_back();
			tail.last = 1'b1;
			step_words.push_back(tail);
		end
		foreach (step_words[i])
			expected_words.push_back(step_words[i]);
	endtask

	function automatic int unsigned phase_now();
		int unsigned p;
		p = (total_items == 0) ? 0 : accepted_count * 3 / total_items;
		return (p > 2) ? 2 : p;
	endfunction

	function automatic int unsigned sender_idle_pct();
		case (phase_now())
			0: return 33;
			1: return 65;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned receiver_idle_pct();
		case (phase_now())
			0: return 65;
			1: return 33;
			default: return 0;
		endcase
	endfunction

	// Source side: offer the next pending byte, or idle, once the current byte is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			unesc_mode = MODE_IDLE;
			code_acc = 16'h0000;
			held_high = 16'h0000;
			low_acc = 16'h0000;
			digit_cnt = 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				decode_byte(in_byte);
				accepted_count++;
			end
			if (in_valid && !in_ready)
				input_stalls++;
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
					in_valid <= 1'b1;
					in_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: check each accepted word against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		result_word_t exp_word;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				words_seen++;
				if (item_kind == jsu_pkg::KIND_CLOSE)
					closes_seen++;
				if (item_kind == jsu_pkg::KIND_ERROR)
					errors_seen++;
				if (expected_words.size() == 0) begin
					$error("Unexpected word: out_byte %02h item_kind %0d error_code %0d last %0b",
						out_byte, item_kind, error_code, last);
					mismatches++;
				end else begin
					exp_word = expected_words.pop_front();
					if (out_byte !== exp_word.data) begin
						$error("out_byte: expected %02h, actual %02h", exp_word.data, out_byte);
						mismatches++;
					end
					if (item_kind !== exp_word.kind) begin
						$error("item_kind: expected %0d, actual %0d", exp_word.kind, item_kind);
						mismatches++;
					end
					if (error_code !== exp_word.err) begin
						$error("error_code: expected %0d, actual %0d", exp_word.err, error_code);
						mismatches++;
					end
					if (last !== exp_word.last) begin
						$error("last: expected %0b, actual %0b", exp_word.last, last);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= (hold_left == 0);
			end else if (!hold_done && phase_now() == 2) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_idle_pct());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d words still expected",
				cycle_count, expected_words.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_hex16(input logic [15:0] v);
		logic [3:0] nib;
		bit upper;
		for (int i = 3; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			upper = $urandom_range(1);
			if (nib < 10)
				pending_bytes.push_back(8'("0" + nib));
			else
				pending_bytes.push_back(8'((upper ? "A" : "a") + nib - 10));
		end
	endtask

	task automatic push_escape_u(input logic [15:0] v);
		pending_bytes.push_back(CH_BSLASH);
		pending_bytes.push_back(CH_U);
		push_hex16(v);
	endtask

	function automatic logic [15:0] pick_code();
		case ($urandom_range(0, 6))
			0: return 16'($urandom_range(0, 'h7F));
			1: return 16'($urandom_range('h80, 'h7FF));
			2: return 16'($urandom_range('h800, 'hD7FF));
			3: return 16'($urandom_range('hE000, 'hFFFF));
			4: return 16'($urandom_range('hDC00, 'hDFFF));
			default: begin
				case ($urandom_range(0, 5))
					0: return 16'h0000;
					1: return 16'h007F;
					2: return 16'h0080;
					3: return 16'h07FF;
					4: return 16'h0800;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [15:0] pick_high();
		case ($urandom_range(0, 3))
			0: return 16'hD800;
			1: return 16'hDBFF;
			default: return 16'($urandom_range('hD800, 'hDBFF));
		endcase
	endfunction

	function automatic logic [15:0] pick_low();
		case ($urandom_range(0, 3))
			0: return 16'hDC00;
			1: return 16'hDFFF;
			default: return 16'($urandom_range('hDC00, 'hDFFF));
		endcase
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] pick_bad_hex();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (hex_value(b) < 16);
		return b;
	endfunction

	function automatic logic [7:0] pick_bad_escape();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (escape_known(b));
		return b;
	endfunction

	function automatic logic [7:0] pick_simple_escape();
		case ($urandom_range(0, 7))
			0: return CH_QUOTE;
			1: return CH_BSLASH;
			2: return CH_SLASH;
			3: return "b";
			4: return "f";
			5: return "n";
			6: return "r";
			default: return "t";
		endcase
	endfunction

	task automatic push_partial_hex_then(input logic [7:0] stop_byte);
		int unsigned k;
		k = $urandom_range(0, 3);
		pending_bytes.push_back(CH_BSLASH);
		pending_bytes.push_back(CH_U);
		repeat (k)
			pending_bytes.push_back(8'("0" + $urandom_range(0, 9)));
		pending_bytes.push_back(stop_byte);
	endtask

	// A high surrogate followed by a byte, an escape, a bad tail or a closing quote.
	task automatic push_lone_high(output bit ended);
		ended = 1'b0;
		push_escape_u(pick_high());
		case ($urandom_range(0, 7))
			0: pending_bytes.push_back(pick_plain());
			1: begin
				pending_bytes.push_back(CH_BSLASH);
				pending_bytes.push_back(pick_simple_escape());
			end
			2: push_escape_u(pick_code());
			3: begin
				push_partial_hex_then(pick_bad_hex());
				ended = 1'b1;
			end
			4: begin
				pending_bytes.push_back(CH_BSLASH);
				pending_bytes.push_back(pick_bad_escape());
				ended = 1'b1;
			end
			5: begin
				pending_bytes.push_back(CH_NUL);
				ended = 1'b1;
			end
			6: begin
				push_partial_hex_then(CH_NUL);
				ended = 1'b1;
			end
			default: begin
				pending_bytes.push_back(CH_QUOTE);
				ended = 1'b1;
			end
		endcase
	endtask

	task automatic push_string();
		int unsigned pieces;
		bit ended;
		ended = 1'b0;
		if ($urandom_range(0, 5) == 0)
			pending_bytes.push_back(8'($urandom_range(0, 255)));
		pending_bytes.push_back(CH_QUOTE);
		pieces = $urandom_range(1, 8);
		for (int i = 0; i < pieces && !ended; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: pending_bytes.push_back(pick_plain());
				4: pending_bytes.push_back(8'($urandom_range('h80, 'hFF)));
				5, 6, 7: begin
					pending_bytes.push_back(CH_BSLASH);
					pending_bytes.push_back(pick_simple_escape());
				end
				8, 9, 10: push_escape_u(pick_code());
				11, 12, 13: begin
					push_escape_u(pick_high());
					push_escape_u(pick_low());
				end
				14, 15, 16: push_lone_high(ended);
				17: begin
					pending_bytes.push_back(CH_BSLASH);
					pending_bytes.push_back(pick_bad_escape());
					ended = 1'b1;
				end
				18: begin
					push_partial_hex_then(pick_bad_hex());
					ended = 1'b1;
				end
				default: begin
					case ($urandom_range(0, 2))
						0: pending_bytes.push_back(CH_NUL);
						1: begin
							pending_bytes.push_back(CH_BSLASH);
							pending_bytes.push_back(CH_NUL);
						end
						default: push_partial_hex_then(CH_NUL);
					endcase
					ended = 1'b1;
				end
			endcase
		end
		if (!ended)
			pending_bytes.push_back(CH_QUOTE);
	endtask

	initial begin
		logic [7:0] directed[$];
		int unsigned directed_count;
		directed = '{
			CH_NUL, "x", CH_QUOTE, 8'hFF,
			CH_BSLASH, CH_U, "0", "7", "F", "F",
			CH_BSLASH, CH_U, "D", "B", "F", "F", CH_BSLASH, CH_U, "d", "f", "f", "f",
			CH_BSLASH, "q",
			CH_QUOTE, CH_BSLASH, CH_NUL
		};
		foreach (directed[i])
			pending_bytes.push_back(directed[i]);
		directed_count = pending_bytes.size();
		while (pending_bytes.size() < directed_count + RANDOM_BYTES)
			push_string();
		pending_bytes.push_back(CH_QUOTE);
		pending_bytes.push_back("o");
		pending_bytes.push_back("k");
		pending_bytes.push_back(CH_QUOTE);
		total_items = pending_bytes.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() > 0 || in_valid || expected_words.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d bytes (%0d directed); checked %0d words, %0d closes, %0d errors.",
			accepted_count, directed_count, words_seen, closes_seen, errors_seen);
		$display("Input was held off for %0d cycles; %0d field mismatches.",
			input_stalls, mismatches);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
